// File: rtl/core/sled_pkg.sv
package sled_pkg;

  // Decoder position inside the literal.
  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_STR    = 3'd1,
    M_ESC    = 3'd2,
    M_UOPEN  = 3'd3,
    M_UFIRST = 3'd4,
    M_UDIGIT = 3'd5,
    M_UUNDER = 3'd6,
    M_HEX2   = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_UNTERM  = 3'd3,
    ST_CONTROL = 3'd4,
    ST_BADESC  = 3'd5,
    ST_BADUNI  = 3'd6,
    ST_RANGE   = 3'd7
  } status_e;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CodeWidth  = 64;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChApos   = 8'h27;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDel    = 8'h7F;

  localparam logic [CodeWidth-1:0] SurrLo    = 64'h0000_0000_0000_D800;
  localparam logic [CodeWidth-1:0] SurrHi    = 64'h0000_0000_0000_E000;
  localparam logic [CodeWidth-1:0] CodeLimit = 64'h0000_0000_0011_0000;
  localparam logic [CodeWidth-1:0] Lim1Byte  = 64'h0000_0000_0000_0080;
  localparam logic [CodeWidth-1:0] Lim2Byte  = 64'h0000_0000_0000_0800;
  localparam logic [CodeWidth-1:0] Lim3Byte  = 64'h0000_0000_0001_0000;

  localparam logic [7:0] Lead2 = 8'b1100_0000;
  localparam logic [7:0] Lead3 = 8'b1110_0000;
  localparam logic [7:0] Lead4 = 8'b1111_0000;
  localparam logic [7:0] Cont  = 8'b1000_0000;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       input_ended;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } out_word_t;

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/string_literal_escape_decoder.sv
// Channel | Direction | Handshake                | Word
// in      | input     | in_valid_i / in_stall_o  | in_word_i  (in_byte, input_ended)
// out     | output    | out_valid_o / out_stall_i| out_word_o (out_byte, status, last)
//
// Each cycle, unless stalled, one input word is decoded into a four-entry burst
// register and one result leaves it. A word with several results holds the input
// until the burst is down to its final entry, so plain text streams at one byte per
// cycle while the output flows; only the close of a unicode escape yields several.
// Reset returns the decoder to idle with an empty burst register. A stall on the
// output holds the current result and, at the burst's final entry, the input as well.
module string_literal_escape_decoder
  import sled_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  mode_e                mode_q, mode_d;
  logic [3:0]           hn_q, hn_d;
  logic [CodeWidth-1:0] cp_q, cp_d;
  logic                 ov_q, ov_d;

  out_word_t buf_q [MaxResults];
  out_word_t buf_d [MaxResults];
  out_word_t res   [MaxResults];
  logic [2:0] rem_q, rem_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] n_res;

  logic       accept, pop;
  logic [7:0] c;
  logic [4:0] hx;
  logic [20:0] u;

  assign pop         = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((rem_q == 3'd0) || (rem_q == 3'd1 && pop));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (rem_q != 3'd0);
  assign out_word_o  = buf_q[rd_q];

  assign c  = in_word_i.in_byte;
  assign hx = hex_digit(c);
  assign u  = cp_q[20:0];

  always_comb begin
    mode_d = mode_q;
    hn_d   = hn_q;
    cp_d   = cp_q;
    ov_d   = ov_q;
    n_res  = 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '{out_byte: 8'd0, status: ST_BYTE, last: 1'b0};
    end

    if (in_word_i.input_ended) begin
      res[0] = '{8'd0, (mode_q == M_IDLE) ? ST_NOQUOTE : ST_UNTERM, 1'b1};
      n_res  = 3'd1;
      mode_d = M_IDLE;
    end else begin
      case (mode_q)
        M_IDLE: begin
          if (c == ChQuote) begin
            mode_d = M_STR;
          end else begin
            res[0] = '{8'd0, ST_NOQUOTE, 1'b1};
            n_res  = 3'd1;
          end
        end
        M_STR: begin
          if (c == ChQuote) begin
            res[0] = '{8'd0, ST_CLOSED, 1'b1};
            n_res  = 3'd1;
            mode_d = M_IDLE;
          end else if (c == ChBslash) begin
            mode_d = M_ESC;
          end else if (c < ChSpace || c == ChDel) begin
            res[0] = '{8'd0, ST_CONTROL, 1'b1};
            n_res  = 3'd1;
            mode_d = M_IDLE;
          end else begin
            res[0] = '{c, ST_BYTE, 1'b1};
            n_res  = 3'd1;
          end
        end
        M_ESC: begin
          mode_d = M_STR;
          n_res  = 3'd1;
          if (c == ChLowT) begin
            res[0] = '{ChTab, ST_BYTE, 1'b1};
          end else if (c == ChLowN) begin
            res[0] = '{ChLf, ST_BYTE, 1'b1};
          end else if (c == ChLowR) begin
            res[0] = '{ChCr, ST_BYTE, 1'b1};
          end else if (c == ChBslash || c == ChQuote || c == ChApos) begin
            res[0] = '{c, ST_BYTE, 1'b1};
          end else if (c == ChLowU) begin
            n_res  = 3'd0;
            mode_d = M_UOPEN;
          end else if (hx[4]) begin
            n_res  = 3'd0;
            hn_d   = hx[3:0];
            mode_d = M_HEX2;
          end else begin
            res[0] = '{8'd0, ST_BADESC, 1'b1};
            mode_d = M_IDLE;
          end
        end
        M_UOPEN: begin
          if (c != ChLbrace) begin
            res[0] = '{8'd0, ST_BADESC, 1'b1};
            n_res  = 3'd1;
            mode_d = M_IDLE;
          end else begin
            cp_d   = '0;
            ov_d   = 1'b0;
            mode_d = M_UFIRST;
          end
        end
        M_UFIRST, M_UUNDER: begin
          if (!hx[4]) begin
            res[0] = '{8'd0, ST_BADUNI, 1'b1};
            n_res  = 3'd1;
            mode_d = M_IDLE;
          end else begin
            ov_d   = ov_q || (cp_q[CodeWidth-1 -: 4] != 4'd0);
            cp_d   = {cp_q[CodeWidth-5:0], hx[3:0]};
            mode_d = M_UDIGIT;
          end
        end
        M_UDIGIT: begin
          if (hx[4]) begin
            ov_d = ov_q || (cp_q[CodeWidth-1 -: 4] != 4'd0);
            cp_d = {cp_q[CodeWidth-5:0], hx[3:0]};
          end else if (c == ChUnder) begin
            mode_d = M_UUNDER;
          end else if (ov_q || c != ChRbrace) begin
            res[0] = '{8'd0, ST_BADUNI, 1'b1};
            n_res  = 3'd1;
            mode_d = M_IDLE;
          end else if ((cp_q >= SurrLo && cp_q < SurrHi) || cp_q >= CodeLimit) begin
            res[0] = '{8'd0, ST_RANGE, 1'b1};
            n_res  = 3'd1;
            mode_d = M_IDLE;
          end else begin
            mode_d = M_STR;
            if (cp_q < Lim1Byte) begin
              res[0] = '{{1'b0, u[6:0]}, ST_BYTE, 1'b1};
              n_res  = 3'd1;
            end else if (cp_q < Lim2Byte) begin
              res[0] = '{Lead2 | {3'd0, u[10:6]}, ST_BYTE, 1'b0};
              res[1] = '{Cont | {2'd0, u[5:0]}, ST_BYTE, 1'b1};
              n_res  = 3'd2;
            end else if (cp_q < Lim3Byte) begin
              res[0] = '{Lead3 | {4'd0, u[15:12]}, ST_BYTE, 1'b0};
              res[1] = '{Cont | {2'd0, u[11:6]}, ST_BYTE, 1'b0};
              res[2] = '{Cont | {2'd0, u[5:0]}, ST_BYTE, 1'b1};
              n_res  = 3'd3;
            end else begin
              res[0] = '{Lead4 | {5'd0, u[20:18]}, ST_BYTE, 1'b0};
              res[1] = '{Cont | {2'd0, u[17:12]}, ST_BYTE, 1'b0};
              res[2] = '{Cont | {2'd0, u[11:6]}, ST_BYTE, 1'b0};
              res[3] = '{Cont | {2'd0, u[5:0]}, ST_BYTE, 1'b1};
              n_res  = 3'd4;
            end
          end
        end
        M_HEX2: begin
          n_res = 3'd1;
          if (!hx[4]) begin
            res[0] = '{8'd0, ST_BADESC, 1'b1};
            mode_d = M_IDLE;
          end else begin
            res[0] = '{{hn_q, hx[3:0]}, ST_BYTE, 1'b1};
            mode_d = M_STR;
          end
        end
        default: begin
          mode_d = M_IDLE;
        end
      endcase
    end
  end

  // Burst register: load a fresh set of results, or step through the current one.
  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    rd_d  = rd_q;
    if (accept) begin
      buf_d = res;
      rem_d = n_res;
      rd_d  = 2'd0;
    end else if (pop) begin
      rem_d = rem_q - 3'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      hn_q   <= 4'd0;
      cp_q   <= '0;
      ov_q   <= 1'b0;
      rem_q  <= 3'd0;
      rd_q   <= 2'd0;
    end else begin
      rem_q <= rem_d;
      rd_q  <= rd_d;
      if (accept) begin
        mode_q <= mode_d;
        hn_q   <= hn_d;
        cp_q   <= cp_d;
        ov_q   <= ov_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// File: rtl/core/sled_checker.sv
module sled_checker
  import sled_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // A close or an error is always the only result of its word.
  a_report_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_BYTE |-> out_word_o.last)
    else $error("close or error word without last");

  // While a burst still has more than one word to go, no new input is taken.
  a_burst_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> in_stall_o)
    else $error("input taken in the middle of a burst");

  // Once a non-final word of a burst leaves, the next one follows at once.
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_word_o.last |=> out_valid_o)
    else $error("burst broken off");

  // With nothing waiting on the output the input is never stalled.
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

endmodule

bind string_literal_escape_decoder sled_checker u_sled_checker (.*);

// File: test/sled_decode_monitor.sv
module sled_decode_monitor
  import sled_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        pending_o
);

  mode_e       mode_q          = M_IDLE;
  logic [3:0]  high_nibble_q   = 4'd0;
  logic [63:0] code_point_q    = 64'd0;
  logic        code_overflow_q = 1'b0;
  out_word_t   expected_words[$];
  int          fail_count      = 0;
  int          pending         = 0;
  int          results_seen    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic report_mismatch(string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    fail_count++;
  endtask

  task automatic push_expected(logic [7:0] b, status_e s, logic l);
    out_word_t w;
    w.out_byte = b;
    w.status   = s;
    w.last     = l;
    expected_words.push_back(w);
  endtask

  task automatic close_with(status_e s);
    push_expected(8'd0, s, 1'b1);
    mode_q = M_IDLE;
  endtask

  // The overflow flag is sticky until the next opening brace.
  task automatic shift_in_digit(logic [3:0] d);
    if (code_point_q[63:60] != 4'd0) begin
      code_overflow_q = 1'b1;
    end
    code_point_q = {code_point_q[59:0], d};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [7:0]  c;
    logic [63:0] u;
    int          nib;
    out_word_t   want;
    if (!rst_ni) begin
      mode_q          = M_IDLE;
      high_nibble_q   = 4'd0;
      code_point_q    = 64'd0;
      code_overflow_q = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        c   = in_word_i.in_byte;
        nib = -1;
        if (c >= 8'h30 && c <= 8'h39) begin
          nib = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
          nib = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
          nib = c - 8'h57;
        end
        if (in_word_i.input_ended) begin
          close_with(mode_q == M_IDLE ? ST_NOQUOTE : ST_UNTERM);
        end else begin
          case (mode_q)
            M_IDLE: begin
              if (c == ChQuote) mode_q = M_STR;
              else close_with(ST_NOQUOTE);
            end
            M_STR: begin
              if (c == ChQuote) close_with(ST_CLOSED);
              else if (c == ChBslash) mode_q = M_ESC;
              else if (c < ChSpace || c == ChDel) close_with(ST_CONTROL);
              else push_expected(c, ST_BYTE, 1'b1);
            end
            M_ESC: begin
              mode_q = M_STR;
              if (c == ChLowT) push_expected(ChTab, ST_BYTE, 1'b1);
              else if (c == ChLowN) push_expected(ChLf, ST_BYTE, 1'b1);
              else if (c == ChLowR) push_expected(ChCr, ST_BYTE, 1'b1);
              else if (c == ChBslash || c == ChQuote || c == ChApos) begin
                push_expected(c, ST_BYTE, 1'b1);
              end else if (c == ChLowU) begin
                mode_q = M_UOPEN;
              end else if (nib >= 0) begin
                high_nibble_q = nib[3:0];
                mode_q        = M_HEX2;
              end else begin
                close_with(ST_BADESC);
              end
            end
            M_UOPEN: begin
              if (c != ChLbrace) begin
                close_with(ST_BADESC);
              end else begin
                code_point_q    = 64'd0;
                code_overflow_q = 1'b0;
                mode_q          = M_UFIRST;
              end
            end
            M_UFIRST, M_UUNDER: begin
              if (nib < 0) begin
                close_with(ST_BADUNI);
              end else begin
                shift_in_digit(nib[3:0]);
                mode_q = M_UDIGIT;
              end
            end
            M_UDIGIT: begin
              if (nib >= 0) begin
                shift_in_digit(nib[3:0]);
              end else if (c == ChUnder) begin
                mode_q = M_UUNDER;
              end else if (code_overflow_q || c != ChRbrace) begin
                close_with(ST_BADUNI);
              end else begin
                // Closing brace: range-check the code point and encode it as UTF-8.
                u      = code_point_q;
                mode_q = M_STR;
                if ((u >= SurrLo && u < SurrHi) || u >= CodeLimit) begin
                  close_with(ST_RANGE);
                end else if (u < Lim1Byte) begin
                  push_expected(u[7:0], ST_BYTE, 1'b1);
                end else if (u < Lim2Byte) begin
                  push_expected(Lead2 | {3'b000, u[10:6]}, ST_BYTE, 1'b0);
                  push_expected(Cont | {2'b00, u[5:0]}, ST_BYTE, 1'b1);
                end else if (u < Lim3Byte) begin
                  push_expected(Lead3 | {4'b0000, u[15:12]}, ST_BYTE, 1'b0);
                  push_expected(Cont | {2'b00, u[11:6]}, ST_BYTE, 1'b0);
                  push_expected(Cont | {2'b00, u[5:0]}, ST_BYTE, 1'b1);
                end else begin
                  push_expected(Lead4 | {5'b00000, u[20:18]}, ST_BYTE, 1'b0);
                  push_expected(Cont | {2'b00, u[17:12]}, ST_BYTE, 1'b0);
                  push_expected(Cont | {2'b00, u[11:6]}, ST_BYTE, 1'b0);
                  push_expected(Cont | {2'b00, u[5:0]}, ST_BYTE, 1'b1);
                end
              end
            end
            M_HEX2: begin
              if (nib < 0) begin
                close_with(ST_BADESC);
              end else begin
                mode_q = M_STR;
                push_expected({high_nibble_q, nib[3:0]}, ST_BYTE, 1'b1);
              end
            end
            default: begin
              mode_q = M_IDLE;
            end
          endcase
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %h arrived with nothing expected", out_word_i));
        end else begin
          want = expected_words.pop_front();
          if (out_word_i.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      out_word_i.out_byte, want.out_byte));
          end
          if (out_word_i.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_word_i.status, want.status));
          end
          if (out_word_i.last !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b", out_word_i.last, want.last));
          end
        end
        results_seen++;
      end
      pending = expected_words.size();
    end
  end

endmodule

// File: test/string_literal_escape_decoder_tb.sv
module string_literal_escape_decoder_tb;
  import sled_pkg::*;

  localparam int RandomWords = 320;
  localparam int CycleLimit  = 400000;
  localparam int HoldStart   = 200;
  localparam int HoldCycles  = 150;

  localparam logic [7:0] SimpleEscapes [6] = '{ChLowT, ChLowN, ChLowR, ChBslash, ChQuote, ChApos};
  localparam logic [63:0] CodeEdges [14] = '{
    64'h0, 64'h7F, 64'h80, 64'h7FF, 64'h800, 64'hD7FF, 64'hD800, 64'hDFFF,
    64'hE000, 64'hFFFF, 64'h10000, 64'h10FFFF, 64'h110000, 64'hFFFF_FFFF_FFFF_FFFF
  };

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;
  int        fail_count;
  int        pending_words;
  int        cycle_count = 0;
  in_word_t  stimulus_words[$];

  always #5 clk_i = ~clk_i;

  string_literal_escape_decoder DUT (.*);

  sled_decode_monitor u_decode_monitor (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i  (in_stall_o),
    .in_word_i,
    .out_valid_i (out_valid_o),
    .out_stall_i,
    .out_word_i  (out_word_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_words)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly short, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66], ChUnder, ChRbrace});
    return b;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hFF));
    while (b inside {ChQuote, ChBslash, ChDel});
    return b;
  endfunction

  task automatic add_byte(logic [7:0] b);
    in_word_t w;
    w.in_byte     = b;
    w.input_ended = 1'b0;
    stimulus_words.push_back(w);
  endtask

  task automatic add_end();
    in_word_t w;
    w.in_byte     = 8'($urandom);
    w.input_ended = 1'b1;
    stimulus_words.push_back(w);
  endtask

  initial begin : drive_input
    logic [7:0]  b;
    logic [63:0] code;
    logic [3:0]  digits[$];
    int          directed;
    int          count;
    int          gap;
    int          width;
    int          mishap;
    bit          alive;
    bit          overflow;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;

    // Stray byte and end of text while idle, then the byte extremes, a four-byte
    // code point with an underscore, a byte escape, a DEL inside the literal, an
    // unterminated literal and an empty one.
    add_byte("x");
    add_end();
    add_byte(ChQuote);
    add_byte(ChSpace);
    add_byte(8'hFF);
    add_byte(ChBslash);
    add_byte(ChLowU);
    add_byte(ChLbrace);
    add_byte("1");
    add_byte("0");
    add_byte("F");
    add_byte("f");
    add_byte(ChUnder);
    add_byte("F");
    add_byte("F");
    add_byte(ChRbrace);
    add_byte(ChBslash);
    add_byte("7");
    add_byte("f");
    add_byte(ChDel);
    add_byte(ChQuote);
    add_end();
    add_byte(ChQuote);
    add_byte(ChQuote);
    directed = stimulus_words.size();

    while (stimulus_words.size() < directed + RandomWords) begin
      if ($urandom_range(0, 11) == 0) begin
        do b = 8'($urandom);
        while (b == ChQuote);
        add_byte(b);
      end
      if ($urandom_range(0, 23) == 0) add_end();
      add_byte(ChQuote);
      count = $urandom_range(0, 6);
      alive = 1'b1;
      for (int k = 0; k < count && alive; k++) begin
        case ($urandom_range(0, 11))
          5: begin
            add_byte(ChBslash);
            add_byte(SimpleEscapes[$urandom_range(0, 5)]);
          end
          6: begin
            add_byte(ChBslash);
            add_byte(hex_char(4'($urandom)));
            add_byte(hex_char(4'($urandom)));
          end
          7, 8, 9: begin
            add_byte(ChBslash);
            add_byte(ChLowU);
            add_byte(ChLbrace);
            overflow = 1'b0;
            case ($urandom_range(0, 10))
              0, 1: code = 64'($urandom_range(0, 'h7F));
              2: code = 64'($urandom_range('h80, 'h7FF));
              3: code = 64'($urandom_range('h800, 'hD7FF));
              4: code = 64'($urandom_range('hE000, 'hFFFF));
              5, 6: code = 64'($urandom_range('h10000, 'h10FFFF));
              7: code = CodeEdges[$urandom_range(0, 13)];
              8: code = 64'($urandom_range('hD800, 'hDFFF));
              9: begin
                code = $urandom_range(0, 1) ? {$urandom, $urandom} : {32'd0, $urandom};
                if (code < CodeLimit) code = code + CodeLimit;
              end
              default: begin
                code     = {$urandom, $urandom};
                overflow = 1'b1;
              end
            endcase
            digits.delete();
            if (overflow) begin
              // A nonzero lead ahead of sixteen more digits no longer fits in 64 bits.
              digits.push_back(4'($urandom_range(1, 15)));
              repeat ($urandom_range(0, 2)) digits.push_back(4'($urandom));
              width = 16;
            end else begin
              width = 1;
              for (int i = 15; i > 0; i--) begin
                if (code[4*i +: 4] != 4'd0 && width == 1) width = i + 1;
              end
              repeat ($urandom_range(0, 7) == 0 ? $urandom_range(1, 18) : 0) begin
                digits.push_back(4'd0);
              end
            end
            for (int i = width - 1; i >= 0; i--) digits.push_back(code[4*i +: 4]);
            mishap = $urandom_range(0, 15);
            if (mishap == 0) begin
              case ($urandom_range(0, 2))
                0: add_byte(ChRbrace);
                1: add_byte(ChUnder);
                default: add_byte(non_hex_byte());
              endcase
              alive = 1'b0;
            end else begin
              foreach (digits[i]) begin
                if (i > 0 && $urandom_range(0, 5) == 0) add_byte(ChUnder);
                add_byte(hex_char(digits[i]));
              end
              case (mishap)
                1: begin
                  add_byte(ChUnder);
                  add_byte($urandom_range(0, 1) ? ChUnder : ChRbrace);
                  alive = 1'b0;
                end
                2: begin
                  add_byte(non_hex_byte());
                  alive = 1'b0;
                end
                3: begin
                  add_end();
                  alive = 1'b0;
                end
                default: begin
                  add_byte(ChRbrace);
                  alive = !(overflow || (code >= SurrLo && code < SurrHi) || code >= CodeLimit);
                end
              endcase
            end
          end
          10: begin
            alive = 1'b0;
            case ($urandom_range(0, 5))
              0: begin
                b = 8'($urandom_range(0, 32));
                add_byte(b == ChSpace ? ChDel : b);
              end
              1: begin
                add_byte(ChBslash);
                do b = non_hex_byte();
                while (b inside {ChLowT, ChLowN, ChLowR, ChBslash, ChQuote, ChApos, ChLowU});
                add_byte(b);
              end
              2: begin
                add_byte(ChBslash);
                add_byte(hex_char(4'($urandom)));
                add_byte(non_hex_byte());
              end
              3: begin
                add_byte(ChBslash);
                add_byte(ChLowU);
                do b = 8'($urandom);
                while (b == ChLbrace);
                add_byte(b);
              end
              4: begin
                add_byte(ChBslash);
                add_end();
              end
              default: add_end();
            endcase
          end
          default: add_byte(plain_byte());
        endcase
      end
      if (alive) begin
        if ($urandom_range(0, 11) == 0) add_end();
        else add_byte(ChQuote);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (stimulus_words[i]) begin
      gap = (i % 64 < 12 || $urandom_range(0, 1) == 1) ? 0 : idle_len();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_word_i  <= stimulus_words[i];
      do @(posedge clk_i);
      while (in_stall_o);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_words == 0);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : drive_output
    int cycle;
    int hold;
    int run_left;
    bit stalling;
    cycle       = 0;
    hold        = 0;
    run_left    = 0;
    stalling    = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cycle++;
      // One long hold-off while words keep coming, so the burst register fills
      // and the block has to stall its input.
      if (cycle == HoldStart) hold = HoldCycles;
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 3) == 0);
          run_left = stalling ? idle_len() : $urandom_range(1, 30);
        end
        run_left--;
        out_stall_i <= stalling;
      end
    end
  end

endmodule
